>>> hw/rtl/fpaq_pkg.sv
// shared types and constants for the q24.8 fixed-point alu
package fpaq_pkg;

	localparam int WORD_BITS_DEF     = 32;
	localparam int FRACTION_BITS_DEF = 8;

	// operation codes as carried in the cmd field
	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_INC      = 4'd4,
		OP_DEC      = 4'd5,
		OP_MIN      = 4'd6,
		OP_MAX      = 4'd7,
		OP_TO_INT   = 4'd8,
		OP_FROM_INT = 4'd9
	} op_t;

	// classification passed from the front part to the back part
	typedef struct packed {
		op_t  op;
		logic lt;
		logic eq;
		logic gt;
		logic neg;
		logic ovf;
		logic dz;
	} ctrl_t;

endpackage

>>> hw/rtl/fpaq_front.sv
// front part: unpacks a transaction, compares, and computes the simple operations combinationally
module fpaq_front #(
	parameter int WORD_BITS     = fpaq_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = fpaq_pkg::FRACTION_BITS_DEF,
	parameter int IN_BITS       = ((4 + 2 * WORD_BITS + 7) / 8) * 8
) (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_BITS-1:0]   s_tdata,
	output logic                 wr_valid,
	input  logic                 wr_ready,
	output fpaq_pkg::ctrl_t      wr_ctrl,
	output logic [WORD_BITS-1:0] wr_res,
	output logic [WORD_BITS-1:0] wr_ma,
	output logic [WORD_BITS-1:0] wr_mb
);

	localparam int W = WORD_BITS;
	localparam int F = FRACTION_BITS;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic [3:0]          cmd;
	logic signed [W-1:0] a;
	logic signed [W-1:0] b;
	logic signed [W:0]   sum;
	logic signed [W:0]   addend;
	logic [W+F-1:0]      shl;
	fpaq_pkg::ctrl_t     c;
	logic [W-1:0]        res;

	assign cmd = s_tdata[3:0];
	assign a   = s_tdata[4 +: W];
	assign b   = s_tdata[4 + W +: W];

	// handshake into the queue
	assign wr_valid = s_tvalid;
	assign s_tready = wr_ready;

	// shared wide adder for add, sub, inc and dec
	always_comb begin
		addend  = {b[W-1], b};
		case (fpaq_pkg::op_t'(cmd))
			fpaq_pkg::OP_ADD: addend = {b[W-1], b};
			fpaq_pkg::OP_SUB: addend = -{b[W-1], b};
			fpaq_pkg::OP_INC: addend = (W+1)'(1);
			fpaq_pkg::OP_DEC: addend = {(W+1){1'b1}};
			default:          addend = {b[W-1], b};
		endcase
		sum = {a[W-1], a} + addend;
		shl = {a, {F{1'b0}}};
	end

	// classify and compute the simple results
	always_comb begin
		c.op  = fpaq_pkg::op_t'(cmd);
		c.lt  = a < b;
		c.eq  = a == b;
		c.gt  = a > b;
		c.neg = a[W-1] ^ b[W-1];
		c.ovf = 1'b0;
		c.dz  = 1'b0;
		res   = '0;
		unique case (fpaq_pkg::op_t'(cmd))
			fpaq_pkg::OP_ADD, fpaq_pkg::OP_SUB, fpaq_pkg::OP_INC, fpaq_pkg::OP_DEC: begin
				if (sum[W] != sum[W-1]) begin
					c.ovf = 1'b1;
					res   = sum[W] ? MINV : MAXV;
				end else begin
					res = sum[W-1:0];
				end
			end
			fpaq_pkg::OP_DIV: begin
				if (b == '0) begin
					c.dz = 1'b1;
					res  = a[W-1] ? MINV : MAXV;
				end
			end
			fpaq_pkg::OP_MIN:    res = (a < b) ? a : b;
			fpaq_pkg::OP_MAX:    res = (a < b) ? b : a;
			fpaq_pkg::OP_TO_INT: res = W'(a >>> F);
			fpaq_pkg::OP_FROM_INT: begin
				if ((&shl[W+F-1:W-1]) || !(|shl[W+F-1:W-1])) begin
					res = shl[W-1:0];
				end else begin
					c.ovf = 1'b1;
					res   = a[W-1] ? MINV : MAXV;
				end
			end
			default: res = '0;
		endcase
	end

	assign wr_ctrl = c;
	assign wr_res  = res;
	assign wr_ma   = a[W-1] ? W'(-a) : W'(a);
	assign wr_mb   = b[W-1] ? W'(-b) : W'(b);

endmodule

>>> hw/rtl/fpaq_queue.sv
// two-entry queue between the front and back parts
module fpaq_queue #(
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  logic [DATA_BITS-1:0] wr_data,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output logic [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem_q [2];
	logic                 wptr_q;
	logic                 rptr_q;
	logic [1:0]           cnt_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> hw/rtl/fpaq_back.sv
// back part: multiplier, pipelined restoring divider, rounding and saturation
module fpaq_back #(
	parameter int WORD_BITS     = fpaq_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = fpaq_pkg::FRACTION_BITS_DEF,
	parameter int OUT_BITS      = ((WORD_BITS + 5 + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fpaq_pkg::ctrl_t      in_ctrl,
	input  logic [WORD_BITS-1:0] in_res,
	input  logic [WORD_BITS-1:0] in_ma,
	input  logic [WORD_BITS-1:0] in_mb,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_BITS-1:0]  m_tdata
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int QW = W + F;
	localparam int PW = 2 * W;
	localparam int MW = PW + 1;
	localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);
	localparam logic [MW-1:0] LIM_POS = MW'(MAXV);
	localparam logic [MW-1:0] LIM_NEG = MW'(MINV);

	logic            en;
	logic            vld_s  [QW+1];
	fpaq_pkg::ctrl_t ctrl_s [QW+1];
	logic [W-1:0]    res_s  [QW+1];
	logic [W-1:0]    mb_s   [QW+1];
	logic [PW-1:0]   prod_s [QW+1];
	logic [QW-1:0]   num_s  [QW+1];
	logic [QW-1:0]   quo_s  [QW+1];
	logic [W-1:0]    rem_s  [QW+1];

	// whole pipeline moves unless a result waits at a stalled output
	assign en       = !m_tvalid || m_tready;
	assign in_ready = en;

	// stage 0: multiply magnitudes and load the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s[0] <= in_ctrl;
			res_s[0]  <= in_res;
			mb_s[0]   <= in_mb;
			prod_s[0] <= PW'(in_ma) * PW'(in_mb);
			num_s[0]  <= {in_ma, {F{1'b0}}};
			quo_s[0]  <= '0;
			rem_s[0]  <= '0;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [W:0] trial;
		logic       ge;

		assign trial = {rem_s[k], num_s[k][QW-1]};
		assign ge    = trial >= {1'b0, mb_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctrl_s[k+1] <= ctrl_s[k];
				res_s[k+1]  <= res_s[k];
				mb_s[k+1]   <= mb_s[k];
				prod_s[k+1] <= prod_s[k];
				num_s[k+1]  <= num_s[k] << 1;
				quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
				rem_s[k+1]  <= ge ? W'(trial - {1'b0, mb_s[k]}) : trial[W-1:0];
			end
		end
	end : g_div

	// rounding, sign and saturation of products and quotients
	fpaq_pkg::ctrl_t cf;
	logic [PW-1:0]   pr;
	logic [MW-1:0]   mag;
	logic            rnd;
	logic [W-1:0]    rsel;
	logic            ovf;

	always_comb begin
		cf   = ctrl_s[QW];
		pr   = prod_s[QW] + HALF;
		rnd  = rem_s[QW] >= (mb_s[QW] - rem_s[QW]);
		mag  = (cf.op == fpaq_pkg::OP_MUL) ? MW'(pr >> F) : MW'(quo_s[QW]) + MW'(rnd);
		rsel = res_s[QW];
		ovf  = cf.ovf;
		if (cf.op == fpaq_pkg::OP_MUL || (cf.op == fpaq_pkg::OP_DIV && !cf.dz)) begin
			if (mag > (cf.neg ? LIM_NEG : LIM_POS)) begin
				ovf  = 1'b1;
				rsel = cf.neg ? MINV : MAXV;
			end else begin
				rsel = cf.neg ? W'(-mag[W-1:0]) : mag[W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= OUT_BITS'({cf.dz, ovf, cf.gt, cf.eq, cf.lt, rsel});
		end
	end

endmodule

>>> hw/rtl/fixed_point_alu_q24_8_core.sv
// top level of the signed q24.8 fixed-point alu
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | cmd, operand_a, operand_b
//  m_      | out | m_tvalid/m_tready  | result, less_than, equal, greater_than,
//          |     |                    | overflow, divide_by_zero
//
// one transaction per cycle sustained while m_tready holds; the pipeline depth is set
// by the divider, which resolves one quotient bit per stage.
// a two-entry queue sits between the front and back parts.
// the back pipeline stalls as a whole only while a result waits at m_.
// arst_n clears all valid state; no pass after reset is needed.
module fixed_point_alu_q24_8_core #(
	parameter int WORD_BITS     = fpaq_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = fpaq_pkg::FRACTION_BITS_DEF,
	parameter int IN_BITS       = ((4 + 2 * WORD_BITS + 7) / 8) * 8,
	parameter int OUT_BITS      = ((WORD_BITS + 5 + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// cmd, operand_a, operand_b
	input  logic [IN_BITS-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// result, less_than, equal, greater_than, overflow, divide_by_zero
	output logic [OUT_BITS-1:0] m_tdata
);

	localparam int W  = WORD_BITS;
	localparam int CB = $bits(fpaq_pkg::ctrl_t);
	localparam int DB = CB + 3 * W;

	logic            f_valid;
	logic            f_ready;
	fpaq_pkg::ctrl_t f_ctrl;
	logic [W-1:0]    f_res;
	logic [W-1:0]    f_ma;
	logic [W-1:0]    f_mb;
	logic            q_valid;
	logic            q_ready;
	logic [DB-1:0]   q_data;

	fpaq_front #(
		.WORD_BITS    (WORD_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.IN_BITS      (IN_BITS)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_ctrl (f_ctrl),
		.wr_res  (f_res),
		.wr_ma   (f_ma),
		.wr_mb   (f_mb)
	);

	fpaq_queue #(
		.DATA_BITS(DB)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data ({f_ctrl, f_res, f_ma, f_mb}),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_data (q_data)
	);

	fpaq_back #(
		.WORD_BITS    (WORD_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.OUT_BITS     (OUT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(q_valid),
		.in_ready(q_ready),
		.in_ctrl (fpaq_pkg::ctrl_t'(q_data[DB-1 -: CB])),
		.in_res  (q_data[3*W-1 -: W]),
		.in_ma   (q_data[2*W-1 -: W]),
		.in_mb   (q_data[W-1:0]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

>>> bench/tb.sv
// self-checking bench for the q24.8 fixed-point alu core
module tb;

	localparam int IN_BITS  = 72;
	localparam int OUT_BITS = 40;
	localparam int LATENCY  = 50;
	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;
	localparam int N_RANDOM = 1530;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        dz;
		logic        ovf;
		logic        gt;
		logic        eq;
		logic        lt;
		logic [31:0] res;
	} alu_out_t;

	// saturate a wide signed value to the 32-bit range
	function automatic longint clip(input logic signed [127:0] v, inout bit ovf);
		if (v > MAXV) begin
			ovf = 1;
			return MAXV;
		end
		if (v < MINV) begin
			ovf = 1;
			return MINV;
		end
		return longint'(v);
	endfunction

	// exact q24.8 operation with half-away rounding and saturation
	function automatic alu_out_t alu_predict(input fpaq_pkg::op_t op, input logic [31:0] ua,
		input logic [31:0] ub);
		logic signed [127:0] a, b, ma, mb, q, rem, p;
		alu_out_t o;
		bit ovf, neg;
		longint r;
		a = $signed(ua);
		b = $signed(ub);
		ovf = 0;
		r = 0;
		o = '0;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		case (op)
			fpaq_pkg::OP_ADD: r = clip(a + b, ovf);
			fpaq_pkg::OP_SUB: r = clip(a - b, ovf);
			fpaq_pkg::OP_MUL: begin
				p = (ma * mb + 128) >>> 8;
				r = clip(neg ? -p : p, ovf);
			end
			fpaq_pkg::OP_DIV: begin
				if (b == 0) begin
					o.dz = 1;
					r = a < 0 ? MINV : MAXV;
				end else begin
					q = (ma <<< 8) / mb;
					rem = (ma <<< 8) % mb;
					if (rem >= mb - rem)
						q = q + 1;
					r = clip(neg ? -q : q, ovf);
				end
			end
			fpaq_pkg::OP_INC: r = clip(a + 1, ovf);
			fpaq_pkg::OP_DEC: r = clip(a - 1, ovf);
			fpaq_pkg::OP_MIN: r = a < b ? a : b;
			fpaq_pkg::OP_MAX: r = a < b ? b : a;
			fpaq_pkg::OP_TO_INT: r = longint'(a >>> 8);
			fpaq_pkg::OP_FROM_INT: r = clip(a <<< 8, ovf);
			default: r = 0;
		endcase
		o.res = r[31:0];
		o.lt = a < b;
		o.eq = a == b;
		o.gt = a > b;
		o.ovf = ovf;
		return o;
	endfunction

	// in-order store of predicted results
	class alu_scoreboard;
		alu_out_t pending[$];
		int errors;
		function void note_input(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
			pending.push_back(alu_predict(fpaq_pkg::op_t'(cmd), a, b));
		endfunction
		function void check_result(alu_out_t got);
			alu_out_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected res=%h flags=%b%b%b%b%b, actual res=%h flags=%b%b%b%b%b",
						want.res, want.dz, want.ovf, want.gt, want.eq, want.lt,
						got.res, got.dz, got.ovf, got.gt, got.eq, got.lt);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_BITS-1:0] m_tdata;

	alu_scoreboard sb = new();
	int cycles = 0;
	int hold_off = 0;
	bit sending_done = 0;

	fixed_point_alu_q24_8_core dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// offer one transaction, then wait for acceptance
	task automatic send_op(input logic [3:0] cmd, input logic [31:0] a, input logic [31:0] b,
		input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 9) : 0;
		repeat (gap) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {{(IN_BITS - 68){1'b0}}, b, a, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(cmd, a, b);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 3) - 1;
			3: return $signed($urandom_range(0, 4095)) - 2048;
			4: return {24'($urandom_range(0, 1023)), 8'h80};
			5: return $urandom_range(0, 65535) << 8;
			default: return $urandom;
		endcase
	endfunction

	// receiver with random stalls and one long hold-off
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 0;
				hold_off--;
			end else if ($urandom_range(0, 3) == 0) begin
				wait_n = $urandom_range(0, 9);
				if (wait_n > 0) begin
					m_tready <= 0;
					repeat (wait_n) @(negedge clk);
				end
				m_tready <= 1;
			end else
				m_tready <= 1;
		end
	end

	// result monitor
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(alu_out_t'(m_tdata[36:0]));

	// stimulus
	initial begin
		logic [31:0] edges[6];
		int i;
		edges = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h100};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: every opcode including unused ones against extremes
		for (i = 0; i < 16; i++)
			send_op(i[3:0], edges[i % 6], edges[(i + 3) % 6], 0);
		send_op(fpaq_pkg::OP_DIV, 32'h5, 32'h0, 0);
		send_op(fpaq_pkg::OP_DIV, 32'h80000000, 32'h0, 0);
		send_op(fpaq_pkg::OP_DIV, 32'h0, 32'h0, 0);
		send_op(fpaq_pkg::OP_MUL, 32'h80, 32'h80, 0);
		send_op(fpaq_pkg::OP_MUL, 32'hffffff80, 32'h80, 0);
		send_op(fpaq_pkg::OP_FROM_INT, 32'h00800000, 32'h0, 0);
		send_op(fpaq_pkg::OP_FROM_INT, 32'hff800000, 32'h0, 0);
		send_op(fpaq_pkg::OP_TO_INT, 32'hffffff01, 32'h0, 0);
		send_op(fpaq_pkg::OP_DIV, 32'h80000000, 32'hffffffff, 0);
		// random part; a long receiver hold-off a third of the way in, sender keeps offering
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == 500)
				hold_off = 200;
			send_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand(),
				!(i >= 500 && i < 600));
		end
		s_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
